// File: hdl/gobl_pkg.sv
// gobl_pkg: shared widths, codes, reset values and types for the grid offset lookup
// used by every module under hdl; no dependencies
package gobl_pkg;

	// default store geometry
	localparam int DEF_MAX_CELLS_X = 64;
	localparam int DEF_MAX_CELLS_Y = 64;

	// field widths
	localparam int POS_W    = 24;
	localparam int SCALE_W  = 24;
	localparam int CELLS_W  = 7;
	localparam int CELL_W   = 6;
	localparam int VAL_W    = 32;

	// fixed point layout
	localparam int PROD_W     = POS_W + SCALE_W;   // pos * scale, Q.32
	localparam int MO_W       = PROD_W + 1;        // signed, after subtracting one half
	localparam int Q_SHIFT    = 32;
	localparam int FRAC_SHIFT = 16;
	localparam int IDX_CALC_W = MO_W - Q_SHIFT + 1;
	localparam int FRAC_W     = MO_W - FRAC_SHIFT + 1;
	localparam int DIFF_W     = VAL_W + 1;
	localparam int MUL_W      = DIFF_W + FRAC_W;
	localparam int TERM_W     = MUL_W - FRAC_SHIFT;
	localparam int SUM_W      = TERM_W + 1;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_CELLS_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_X = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y = 2'd3;

	localparam logic [CELLS_W-1:0] RST_CELLS = 7'd1;
	localparam logic [SCALE_W-1:0] RST_SCALE = 24'd65536;

	// item codes
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;
	localparam logic DIR_Y      = 1'b0;
	localparam logic DIR_X      = 1'b1;

	// pipeline register stages, from the input stage to the output register
	localparam int PIPE_DEPTH = 9;

	typedef logic signed [VAL_W-1:0]  val_t;
	typedef logic signed [FRAC_W-1:0] frac_t;

endpackage

// File: hdl/grid_offset_bilinear_lookup.sv
// grid_offset_bilinear_lookup: nine register stages from item acceptance to out_valid, the
// first loads at acceptance; one item per cycle while the output is not stalled; the depth
// is set by two multiply-and-saturate passes (x then y) behind the position multiply and
// the banked grid read. a stalled output holds the pipe, empty stages still fill.
// arst_n clears valid bits and resets the config registers; grid contents are undefined
// until written. uses gobl_pkg, gobl_axis, gobl_lerp, gobl_ram
module grid_offset_bilinear_lookup #(
	parameter int MAX_CELLS_X = gobl_pkg::DEF_MAX_CELLS_X,
	parameter int MAX_CELLS_Y = gobl_pkg::DEF_MAX_CELLS_Y
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// query / write items
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              mode,
	input  logic                              direction,
	input  logic [gobl_pkg::POS_W-1:0]        pos_x,
	input  logic [gobl_pkg::POS_W-1:0]        pos_y,
	input  logic [gobl_pkg::CELL_W-1:0]       cell_x,
	input  logic [gobl_pkg::CELL_W-1:0]       cell_y,
	input  logic signed [gobl_pkg::VAL_W-1:0] entry_value,
	// results
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [gobl_pkg::VAL_W-1:0] offset_value,
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gobl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gobl_pkg::CFG_DATA_W-1:0]   cfg_data
);

	// each grid is split into four banks by column and row parity, so the
	// four corners of a cell always sit in different banks and are read together
	localparam int IXW = $clog2(MAX_CELLS_X);
	localparam int IYW = $clog2(MAX_CELLS_Y);
	localparam int HXW = ($clog2((MAX_CELLS_X + 1) / 2) > 0) ? $clog2((MAX_CELLS_X + 1) / 2) : 1;
	localparam int HYW = ($clog2((MAX_CELLS_Y + 1) / 2) > 0) ? $clog2((MAX_CELLS_Y + 1) / 2) : 1;
	localparam int AW  = 1 + HYW + HXW;   // direction, row pair, column pair
	localparam int BANK_DEPTH = 2 ** AW;
	localparam int WIDE_W = 9;            // holds any cell index up to 256

	// configuration registers
	logic [gobl_pkg::CELLS_W-1:0] cells_x_q;
	logic [gobl_pkg::CELLS_W-1:0] cells_y_q;
	logic [gobl_pkg::SCALE_W-1:0] scale_x_q;
	logic [gobl_pkg::SCALE_W-1:0] scale_y_q;

	// stage enables: a stage loads when it is empty or its item moves on
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8, en_s9;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;

	// item fields riding along with the position math
	logic                           mode_s1, mode_s2;
	logic                           dir_s1, dir_s2;
	logic [gobl_pkg::CELL_W-1:0]    cell_x_s1, cell_x_s2;
	logic [gobl_pkg::CELL_W-1:0]    cell_y_s1, cell_y_s2;
	gobl_pkg::val_t                 value_s1, value_s2;

	// axis mapping results
	logic [IXW-1:0]                 xi_s2;
	logic [IYW-1:0]                 yi_s2;
	gobl_pkg::frac_t                fx_s2, fy_s2;
	logic                           one_x, one_y;

	// bank addressing
	logic [WIDE_W-1:0]              xi_wide, yi_wide, wcx_wide, wcy_wide;
	logic [HXW-1:0]                 col_even, col_odd, wcol;
	logic [HYW-1:0]                 row_even, row_odd, wrow;
	logic [AW-1:0]                  raddr [4];
	logic [AW-1:0]                  waddr;
	logic                           wr_ok;
	logic                           wr_fire;
	gobl_pkg::val_t                 bank_rd [4];

	// corner routing at the bank outputs
	logic                           xpar_s3, ypar_s3;
	gobl_pkg::frac_t                fx_s3;
	gobl_pkg::frac_t                fy_s3, fy_s4, fy_s5, fy_s6;
	gobl_pkg::val_t                 c00, c10, c01, c11;
	gobl_pkg::val_t                 v0, v1;
	gobl_pkg::val_t                 y_res;

	//--------------------------------------------------------------------
	// configuration port, always ready
	//--------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_x_q <= gobl_pkg::RST_CELLS;
			cells_y_q <= gobl_pkg::RST_CELLS;
			scale_x_q <= gobl_pkg::RST_SCALE;
			scale_y_q <= gobl_pkg::RST_SCALE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gobl_pkg::REG_CELLS_X: begin
					cells_x_q <= cfg_data[gobl_pkg::CELLS_W-1:0];
				end
				gobl_pkg::REG_CELLS_Y: begin
					cells_y_q <= cfg_data[gobl_pkg::CELLS_W-1:0];
				end
				gobl_pkg::REG_SCALE_X: begin
					scale_x_q <= cfg_data[gobl_pkg::SCALE_W-1:0];
				end
				gobl_pkg::REG_SCALE_Y: begin
					scale_y_q <= cfg_data[gobl_pkg::SCALE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	//--------------------------------------------------------------------
	// flow control: ready ripples back from the output register so bubbles
	// collapse while the consumer stalls
	//--------------------------------------------------------------------
	assign en_s9 = !vld_s9 || !out_stall;
	assign en_s8 = !vld_s8 || en_s9;
	assign en_s7 = !vld_s7 || en_s8;
	assign en_s6 = !vld_s6 || en_s7;
	assign en_s5 = !vld_s5 || en_s6;
	assign en_s4 = !vld_s4 || en_s5;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;

	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
			// write items retire at the bank write and drop out here
			if (en_s3) vld_s3 <= vld_s2 && (mode_s2 == gobl_pkg::MODE_QUERY);
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
			if (en_s7) vld_s7 <= vld_s6;
			if (en_s8) vld_s8 <= vld_s7;
			if (en_s9) vld_s9 <= vld_s8;
		end
	end

	//--------------------------------------------------------------------
	// stages 1-2: position times scale, then floor / clamp / fraction
	//--------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (en_s1) begin
			mode_s1   <= mode;
			dir_s1    <= direction;
			cell_x_s1 <= cell_x;
			cell_y_s1 <= cell_y;
			value_s1  <= entry_value;
		end
		if (en_s2) begin
			mode_s2   <= mode_s1;
			dir_s2    <= dir_s1;
			cell_x_s2 <= cell_x_s1;
			cell_y_s2 <= cell_y_s1;
			value_s2  <= value_s1;
		end
	end

	gobl_axis #(
		.MAX_CELLS (MAX_CELLS_X)
	) u_axis_x (
		.clk    (clk),
		.en     ({en_s2, en_s1}),
		.pos    (pos_x),
		.scale  (scale_x_q),
		.cells  (cells_x_q),
		.idx    (xi_s2),
		.frac   (fx_s2),
		.single (one_x)
	);

	gobl_axis #(
		.MAX_CELLS (MAX_CELLS_Y)
	) u_axis_y (
		.clk    (clk),
		.en     ({en_s2, en_s1}),
		.pos    (pos_y),
		.scale  (scale_y_q),
		.cells  (cells_y_q),
		.idx    (yi_s2),
		.frac   (fy_s2),
		.single (one_y)
	);

	//--------------------------------------------------------------------
	// bank access from stage 2: reads for queries, one write for write items
	//--------------------------------------------------------------------
	always_comb begin
		xi_wide  = WIDE_W'(xi_s2);
		yi_wide  = WIDE_W'(yi_s2);
		// odd index: the even-parity neighbor is the next pair up
		col_odd  = xi_wide[HXW:1];
		col_even = xi_wide[HXW:1] + HXW'(xi_wide[0]);
		row_odd  = yi_wide[HYW:1];
		row_even = yi_wide[HYW:1] + HYW'(yi_wide[0]);
		// bank index is {row parity, column parity}
		raddr[0] = {dir_s2, row_even, col_even};
		raddr[1] = {dir_s2, row_even, col_odd};
		raddr[2] = {dir_s2, row_odd, col_even};
		raddr[3] = {dir_s2, row_odd, col_odd};

		wcx_wide = WIDE_W'(cell_x_s2);
		wcy_wide = WIDE_W'(cell_y_s2);
		wcol     = wcx_wide[HXW:1];
		wrow     = wcy_wide[HYW:1];
		waddr    = {dir_s2, wrow, wcol};
		// writes outside the store are dropped
		wr_ok    = (32'(cell_x_s2) < MAX_CELLS_X) && (32'(cell_y_s2) < MAX_CELLS_Y);
		wr_fire  = vld_s2 && (mode_s2 == gobl_pkg::MODE_WRITE) && wr_ok && en_s3;
	end

	for (genvar b = 0; b < 4; b++) begin : g_bank
		gobl_ram #(
			.WIDTH (gobl_pkg::VAL_W),
			.DEPTH (BANK_DEPTH)
		) u_bank (
			.clk   (clk),
			.we    (wr_fire && (cell_x_s2[0] == b[0]) && (cell_y_s2[0] == b[1])),
			.waddr (waddr),
			.wdata (value_s2),
			.re    (en_s3),
			.raddr (raddr[b]),
			.rdata (bank_rd[b])
		);
	end

	//--------------------------------------------------------------------
	// stage 3: route bank outputs to the cell corners
	//--------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (en_s3) begin
			xpar_s3 <= xi_s2[0];
			ypar_s3 <= yi_s2[0];
			fx_s3   <= fx_s2;
			fy_s3   <= fy_s2;
		end
		if (en_s4) fy_s4 <= fy_s3;
		if (en_s5) fy_s5 <= fy_s4;
		if (en_s6) fy_s6 <= fy_s5;
	end

	always_comb begin
		c00 = bank_rd[{ypar_s3, xpar_s3}];
		c10 = bank_rd[{ypar_s3, !xpar_s3}];
		c01 = bank_rd[{!ypar_s3, xpar_s3}];
		c11 = bank_rd[{!ypar_s3, !xpar_s3}];
		// a one-cell axis never reads its neighbor: zero difference gives 1d or single entry
		if (one_x) begin
			c10 = c00;
			c11 = c01;
		end
		if (one_y) begin
			c01 = c00;
			c11 = c10;
		end
	end

	//--------------------------------------------------------------------
	// stages 4-6: the two x interpolations, stages 7-9: the y interpolation,
	// whose last register is the output register
	//--------------------------------------------------------------------
	gobl_lerp u_lerp_x0 (
		.clk (clk),
		.en  ({en_s6, en_s5, en_s4}),
		.a   (c00),
		.b   (c10),
		.f   (fx_s3),
		.res (v0)
	);

	gobl_lerp u_lerp_x1 (
		.clk (clk),
		.en  ({en_s6, en_s5, en_s4}),
		.a   (c01),
		.b   (c11),
		.f   (fx_s3),
		.res (v1)
	);

	gobl_lerp u_lerp_y (
		.clk (clk),
		.en  ({en_s9, en_s8, en_s7}),
		.a   (v0),
		.b   (v1),
		.f   (fy_s6),
		.res (y_res)
	);

	assign out_valid    = vld_s9;
	assign offset_value = y_res;

endmodule

// File: hdl/gobl_ram.sv
// gobl_ram: generic single write port, single read port ram with registered read
// uses gobl_pkg for its default width
module gobl_ram #(
	parameter int WIDTH = gobl_pkg::VAL_W,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/gobl_axis.sv
// gobl_axis: two pipeline stages mapping one position axis to a clamped cell index and fraction
// uses gobl_pkg for widths
module gobl_axis #(
	parameter int MAX_CELLS = gobl_pkg::DEF_MAX_CELLS_X,
	localparam int IW = $clog2(MAX_CELLS),
	localparam int CW = $clog2(MAX_CELLS + 1)
) (
	input  logic                           clk,
	input  logic [1:0]                     en,
	input  logic [gobl_pkg::POS_W-1:0]     pos,
	input  logic [gobl_pkg::SCALE_W-1:0]   scale,
	input  logic [gobl_pkg::CELLS_W-1:0]   cells,
	output logic [IW-1:0]                  idx,
	output gobl_pkg::frac_t                frac,
	output logic                           single
);

	localparam logic signed [gobl_pkg::MO_W-1:0] HALF =
		gobl_pkg::MO_W'(1) << (gobl_pkg::Q_SHIFT - 1);

	logic [gobl_pkg::PROD_W-1:0]                 prod_s1;
	logic [IW-1:0]                               idx_s2;
	gobl_pkg::frac_t                             frac_s2;
	logic signed [gobl_pkg::MO_W-1:0]            mo;
	logic [CW-1:0]                               nc;
	logic signed [gobl_pkg::IDX_CALC_W-1:0]      mi_w;
	logic signed [gobl_pkg::IDX_CALC_W-1:0]      hi_w;
	logic signed [gobl_pkg::IDX_CALC_W-1:0]      mc_w;
	gobl_pkg::frac_t                             frac_c;

	// stage 1: exact product, Q.32
	always_ff @(posedge clk) begin
		if (en[0]) begin
			prod_s1 <= gobl_pkg::PROD_W'(pos) * gobl_pkg::PROD_W'(scale);
		end
	end

	// zero cells acts as one, too many acts as the maximum
	always_comb begin
		if (cells == '0) begin
			nc = CW'(1);
		end else if (32'(cells) > MAX_CELLS) begin
			nc = CW'(MAX_CELLS);
		end else begin
			nc = CW'(cells);
		end
	end

	assign single = (cells <= gobl_pkg::CELLS_W'(1));

	// stage 2: subtract one half, floor, clamp to 0..cells-2, fraction against clamped index
	always_comb begin
		mo   = $signed({1'b0, prod_s1}) - HALF;
		mi_w = $signed({mo[gobl_pkg::MO_W-1], mo[gobl_pkg::MO_W-1:gobl_pkg::Q_SHIFT]});
		hi_w = $signed({{(gobl_pkg::IDX_CALC_W - CW){1'b0}}, nc}) -
			gobl_pkg::IDX_CALC_W'(2);
		mc_w = (mi_w > hi_w) ? hi_w : mi_w;
		if (mc_w < 0) begin
			mc_w = '0;
		end
		frac_c = $signed({mo[gobl_pkg::MO_W-1], mo[gobl_pkg::MO_W-1:gobl_pkg::FRAC_SHIFT]}) -
			$signed({mc_w, {gobl_pkg::FRAC_SHIFT{1'b0}}});
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			idx_s2  <= mc_w[IW-1:0];
			frac_s2 <= frac_c;
		end
	end

	assign idx  = idx_s2;
	assign frac = frac_s2;

endmodule

// File: hdl/gobl_lerp.sv
// gobl_lerp: three stage linear interpolation a + floor((b-a)*f / 2^16), saturated to 32 bits
// uses gobl_pkg for widths and types
module gobl_lerp (
	input  logic            clk,
	input  logic [2:0]      en,
	input  gobl_pkg::val_t  a,
	input  gobl_pkg::val_t  b,
	input  gobl_pkg::frac_t f,
	output gobl_pkg::val_t  res
);

	logic signed [gobl_pkg::DIFF_W-1:0] diff_s1;
	gobl_pkg::val_t                     a_s1;
	gobl_pkg::frac_t                    f_s1;
	logic signed [gobl_pkg::MUL_W-1:0]  prod_s2;
	gobl_pkg::val_t                     a_s2;
	gobl_pkg::val_t                     res_s3;
	logic signed [gobl_pkg::SUM_W-1:0]  sum;
	gobl_pkg::val_t                     sat;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			diff_s1 <= $signed({b[gobl_pkg::VAL_W-1], b}) - $signed({a[gobl_pkg::VAL_W-1], a});
			a_s1    <= a;
			f_s1    <= f;
		end
	end

	// full product, overflowing cases saturate below just the same
	always_ff @(posedge clk) begin
		if (en[1]) begin
			prod_s2 <= diff_s1 * f_s1;
			a_s2    <= a_s1;
		end
	end

	always_comb begin
		sum = $signed({{(gobl_pkg::SUM_W - gobl_pkg::VAL_W){a_s2[gobl_pkg::VAL_W-1]}}, a_s2}) +
			$signed({prod_s2[gobl_pkg::MUL_W-1],
				prod_s2[gobl_pkg::MUL_W-1:gobl_pkg::FRAC_SHIFT]});
		if (!sum[gobl_pkg::SUM_W-1] && (|sum[gobl_pkg::SUM_W-2:gobl_pkg::VAL_W-1])) begin
			sat = {1'b0, {(gobl_pkg::VAL_W-1){1'b1}}};
		end else if (sum[gobl_pkg::SUM_W-1] && !(&sum[gobl_pkg::SUM_W-2:gobl_pkg::VAL_W-1])) begin
			sat = {1'b1, {(gobl_pkg::VAL_W-1){1'b0}}};
		end else begin
			sat = sum[gobl_pkg::VAL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			res_s3 <= sat;
		end
	end

	assign res = res_s3;

endmodule

// File: hdl/gobl_checker.sv
// gobl_checker: port-level assertions for grid_offset_bilinear_lookup, bound to the top level
// uses gobl_pkg for codes and pipeline depth
module gobl_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              mode,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic signed [gobl_pkg::VAL_W-1:0] offset_value
);

	// input backs up only behind a full pipe with a stalled result
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a stalled result");

	// a result after an idle output cycle comes from an accepted query
	a_fresh_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |->
			$past(in_valid && !in_stall && (mode == gobl_pkg::MODE_QUERY), gobl_pkg::PIPE_DEPTH))
		else $error("result without a matching query");

	// stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(offset_value)))
		else $error("stalled result changed");

	// a result leaves only when taken
	a_out_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("result dropped while stalled");

endmodule

bind grid_offset_bilinear_lookup gobl_checker u_gobl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.mode         (mode),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.offset_value (offset_value)
);
